// ===== design/atomic_memory_op_unit_macros.svh =====
// assertion macros for the atomic memory operation unit
`ifndef ATOMIC_MEMORY_OP_UNIT_MACROS_SVH
`define ATOMIC_MEMORY_OP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define AMOU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("atomic_memory_op_unit: assertion failed");

// condition that must never be true out of reset
`define AMOU_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("atomic_memory_op_unit: forbidden condition seen");

`else

`define AMOU_ASSERT(label, prop)

`define AMOU_NEVER(label, expr)

`endif

`endif

// ===== design/amou_pkg.sv =====
// types and constants shared by the atomic memory operation unit
package amou_pkg;

    localparam int XLEN = 64;
    localparam int WLEN = 32;

    localparam logic [1:0] KIND_LR  = 2'd0;
    localparam logic [1:0] KIND_SC  = 2'd1;
    localparam logic [1:0] KIND_AMO = 2'd2;

    localparam logic [3:0] AMO_SWAP = 4'd0;
    localparam logic [3:0] AMO_ADD  = 4'd1;
    localparam logic [3:0] AMO_XOR  = 4'd2;
    localparam logic [3:0] AMO_AND  = 4'd3;
    localparam logic [3:0] AMO_OR   = 4'd4;
    localparam logic [3:0] AMO_MIN  = 4'd5;
    localparam logic [3:0] AMO_MAX  = 4'd6;
    localparam logic [3:0] AMO_MINU = 4'd7;
    localparam logic [3:0] AMO_MAXU = 4'd8;

    localparam logic [XLEN-1:0] WORD_LAST_OFFSET  = 64'd3;
    localparam logic [XLEN-1:0] DWORD_LAST_OFFSET = 64'd7;

    localparam logic [XLEN-1:0] SC_SUCCESS = 64'd0;
    localparam logic [XLEN-1:0] SC_FAILURE = 64'd1;

    typedef struct packed {
        logic [1:0]      kind;
        logic            wide;
        logic [3:0]      amo_op;
        logic [XLEN-1:0] address;
        logic [XLEN-1:0] mem_read_data;
        logic [XLEN-1:0] operand;
    } req_t;

    typedef struct packed {
        logic            mem_write;
        logic [XLEN-1:0] mem_write_data;
        logic [XLEN-1:0] rd_value;
    } rsp_t;

    function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
        return {{(XLEN-WLEN){v[WLEN-1]}}, v[WLEN-1:0]};
    endfunction

endpackage

// ===== design/amou_alu.sv =====
// read-modify-write datapath for amo operations in word and doubleword width
module amou_alu (
    input  logic [3:0]                amo_op,
    input  logic                      wide,
    input  logic [amou_pkg::XLEN-1:0] mem_read_data,
    input  logic [amou_pkg::XLEN-1:0] operand,
    output logic [amou_pkg::XLEN-1:0] write_data,
    output logic [amou_pkg::XLEN-1:0] old_value
);

    logic [amou_pkg::XLEN-1:0] a;
    logic [amou_pkg::XLEN-1:0] b;
    logic [amou_pkg::XLEN-1:0] result;
    logic                      lt_signed;
    logic                      lt_unsigned;

    assign a = wide ? mem_read_data : amou_pkg::sext32(mem_read_data);
    assign b = wide ? operand : amou_pkg::sext32(operand);

    assign lt_signed   = $signed(a) < $signed(b);
    assign lt_unsigned = a < b;

    always_comb
    begin
        case (amo_op)
            amou_pkg::AMO_SWAP: result = b;
            amou_pkg::AMO_ADD:  result = a + b;
            amou_pkg::AMO_XOR:  result = a ^ b;
            amou_pkg::AMO_AND:  result = a & b;
            amou_pkg::AMO_OR:   result = a | b;
            amou_pkg::AMO_MIN:  result = lt_signed ? a : b;
            amou_pkg::AMO_MAX:  result = lt_signed ? b : a;
            amou_pkg::AMO_MINU: result = lt_unsigned ? a : b;
            amou_pkg::AMO_MAXU: result = lt_unsigned ? b : a;
            default:            result = '0;
        endcase
    end

    // narrow results are stored zero-extended
    assign write_data = wide ? result
                             : {{(amou_pkg::XLEN-amou_pkg::WLEN){1'b0}},
                                result[amou_pkg::WLEN-1:0]};
    assign old_value  = a;

endmodule

// ===== design/atomic_memory_op_unit.sv =====
// top level of the atomic memory operation unit (lr, sc and amo)
//
// Takes one atomic request per clock while req_ready is high and returns one
// response per request, in order, after the request has passed through the
// input register and then the result register. The whole lr/sc check, the
// reservation update and the amo datapath sit in a single combinational pass
// between those two registers, so a new request can be accepted every cycle;
// a stalled response holds the input register, and req_ready drops only when
// both registers are full. The reservation is one register set updated as
// each request moves into the result register: load-reserved sets it over 4
// or 8 bytes, store-conditional always clears it, and amo requests leave it
// unchanged.
module atomic_memory_op_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  amou_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output amou_pkg::rsp_t rsp
);

    `include "atomic_memory_op_unit_macros.svh"

    logic                      s1_valid_reg;
    amou_pkg::req_t            s1_req_reg;
    logic                      rsp_valid_reg;
    amou_pkg::rsp_t            rsp_reg;
    amou_pkg::rsp_t            rsp_next;
    logic                      advance;

    logic                      resv_valid_reg;
    logic                      resv_valid_next;
    logic [amou_pkg::XLEN-1:0] resv_low_reg;
    logic [amou_pkg::XLEN-1:0] resv_low_next;
    logic [amou_pkg::XLEN-1:0] resv_high_reg;
    logic [amou_pkg::XLEN-1:0] resv_high_next;

    logic [amou_pkg::XLEN-1:0] last_addr;
    logic                      sc_ok;
    logic [amou_pkg::XLEN-1:0] amo_wdata;
    logic [amou_pkg::XLEN-1:0] amo_old;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
    end

    amou_alu u_alu (
        .amo_op        (s1_req_reg.amo_op),
        .wide          (s1_req_reg.wide),
        .mem_read_data (s1_req_reg.mem_read_data),
        .operand       (s1_req_reg.operand),
        .write_data    (amo_wdata),
        .old_value     (amo_old)
    );

    // byte range of the access, wrapping modulo 2^64
    assign last_addr = s1_req_reg.address
                     + (s1_req_reg.wide ? amou_pkg::DWORD_LAST_OFFSET
                                        : amou_pkg::WORD_LAST_OFFSET);

    assign sc_ok = resv_valid_reg
                && (resv_low_reg <= s1_req_reg.address)
                && (resv_high_reg >= last_addr);

    always_comb
    begin
        rsp_next        = '0;
        resv_valid_next = resv_valid_reg;
        resv_low_next   = resv_low_reg;
        resv_high_next  = resv_high_reg;
        case (s1_req_reg.kind)
            amou_pkg::KIND_LR:
            begin
                resv_valid_next   = 1'b1;
                resv_low_next     = s1_req_reg.address;
                resv_high_next    = last_addr;
                rsp_next.rd_value = amo_old;
            end
            amou_pkg::KIND_SC:
            begin
                resv_valid_next = 1'b0;
                if (sc_ok)
                begin
                    rsp_next.mem_write      = 1'b1;
                    rsp_next.mem_write_data = s1_req_reg.wide
                        ? s1_req_reg.operand
                        : {{(amou_pkg::XLEN-amou_pkg::WLEN){1'b0}},
                           s1_req_reg.operand[amou_pkg::WLEN-1:0]};
                    rsp_next.rd_value       = amou_pkg::SC_SUCCESS;
                end
                else
                begin
                    rsp_next.rd_value = amou_pkg::SC_FAILURE;
                end
            end
            amou_pkg::KIND_AMO:
            begin
                rsp_next.mem_write      = 1'b1;
                rsp_next.mem_write_data = amo_wdata;
                rsp_next.rd_value       = amo_old;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // result register and reservation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            resv_valid_reg <= 1'b0;
            resv_low_reg   <= '0;
            resv_high_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                rsp_valid_reg  <= 1'b1;
                resv_valid_reg <= resv_valid_next;
                resv_low_reg   <= resv_low_next;
                resv_high_reg  <= resv_high_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `AMOU_NEVER(a_no_data_without_write,
        rsp_valid && !rsp.mem_write && (rsp.mem_write_data != '0))
    `AMOU_ASSERT(a_lr_sets_reservation,
        (advance && (s1_req_reg.kind == amou_pkg::KIND_LR)) |=> resv_valid_reg)
    `AMOU_ASSERT(a_sc_clears_reservation,
        (advance && (s1_req_reg.kind == amou_pkg::KIND_SC)) |=> !resv_valid_reg)
    `AMOU_ASSERT(a_reservation_falls_on_sc,
        $fell(resv_valid_reg) |->
            $past(advance && (s1_req_reg.kind == amou_pkg::KIND_SC)))
    `AMOU_ASSERT(a_sc_status,
        (advance && (s1_req_reg.kind == amou_pkg::KIND_SC)) |=>
            (rsp.rd_value == (rsp.mem_write ? amou_pkg::SC_SUCCESS
                                            : amou_pkg::SC_FAILURE)))

endmodule

// ===== tb/atomic_memory_op_unit_test.sv =====
// self-checking testbench for the atomic memory operation unit (lr, sc, amo)
`timescale 1ns / 100ps

module atomic_memory_op_unit_test;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [3:0] AMO_LAST_CODE = 4'd15;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         RANDOM_ITEMS  = 900;
    localparam int         REPORT_LIMIT  = 10;

    class amo_response_tracker;
        bit                        resv_valid;
        logic [amou_pkg::XLEN-1:0] resv_low;
        logic [amou_pkg::XLEN-1:0] resv_high;
        amou_pkg::rsp_t            expected_responses[$];
        int                        errors;

        function new();
            resv_valid = 1'b0;
            resv_low   = '0;
            resv_high  = '0;
            errors     = 0;
        endfunction

        function logic [amou_pkg::XLEN-1:0] widen_word(logic [amou_pkg::XLEN-1:0] v);
            return {{(amou_pkg::XLEN-amou_pkg::WLEN){v[amou_pkg::WLEN-1]}},
                    v[amou_pkg::WLEN-1:0]};
        endfunction

        function logic [amou_pkg::XLEN-1:0] amo_apply(logic [3:0] op,
                                                      logic [amou_pkg::XLEN-1:0] a,
                                                      logic [amou_pkg::XLEN-1:0] b);
            case (op)
                amou_pkg::AMO_SWAP: return b;
                amou_pkg::AMO_ADD:  return a + b;
                amou_pkg::AMO_XOR:  return a ^ b;
                amou_pkg::AMO_AND:  return a & b;
                amou_pkg::AMO_OR:   return a | b;
                amou_pkg::AMO_MIN:  return ($signed(a) < $signed(b)) ? a : b;
                amou_pkg::AMO_MAX:  return ($signed(a) < $signed(b)) ? b : a;
                amou_pkg::AMO_MINU: return (a < b) ? a : b;
                amou_pkg::AMO_MAXU: return (a < b) ? b : a;
                default:            return '0;
            endcase
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function void note_request(amou_pkg::req_t r);
            amou_pkg::rsp_t            e;
            logic [amou_pkg::XLEN-1:0] last_byte;
            logic [amou_pkg::XLEN-1:0] a;
            logic [amou_pkg::XLEN-1:0] res;
            e = '0;
            last_byte = r.address + (r.wide ? amou_pkg::DWORD_LAST_OFFSET
                                            : amou_pkg::WORD_LAST_OFFSET);
            case (r.kind)
                amou_pkg::KIND_LR:
                begin
                    resv_valid = 1'b1;
                    resv_low   = r.address;
                    resv_high  = last_byte;
                    e.rd_value = r.wide ? r.mem_read_data : widen_word(r.mem_read_data);
                end
                amou_pkg::KIND_SC:
                begin
                    if (resv_valid && resv_low <= r.address && resv_high >= last_byte)
                    begin
                        e.mem_write      = 1'b1;
                        e.mem_write_data = r.wide
                            ? r.operand
                            : {{(amou_pkg::XLEN-amou_pkg::WLEN){1'b0}},
                               r.operand[amou_pkg::WLEN-1:0]};
                        e.rd_value       = amou_pkg::SC_SUCCESS;
                    end
                    else
                    begin
                        e.rd_value = amou_pkg::SC_FAILURE;
                    end
                    resv_valid = 1'b0;
                end
                amou_pkg::KIND_AMO:
                begin
                    e.mem_write = 1'b1;
                    if (r.wide)
                    begin
                        e.mem_write_data = amo_apply(r.amo_op, r.mem_read_data, r.operand);
                        e.rd_value       = r.mem_read_data;
                    end
                    else
                    begin
                        a   = widen_word(r.mem_read_data);
                        res = amo_apply(r.amo_op, a, widen_word(r.operand));
                        e.mem_write_data = {{(amou_pkg::XLEN-amou_pkg::WLEN){1'b0}},
                                            res[amou_pkg::WLEN-1:0]};
                        e.rd_value       = a;
                    end
                end
                default: ;
            endcase
            expected_responses.push_back(e);
        endfunction

        function void check_response(amou_pkg::rsp_t r);
            amou_pkg::rsp_t e;
            if (expected_responses.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected response: wr=%0b data=%h rd=%h",
                             r.mem_write, r.mem_write_data, r.rd_value);
                return;
            end
            e = expected_responses.pop_front();
            if (r.mem_write !== e.mem_write || r.mem_write_data !== e.mem_write_data ||
                r.rd_value !== e.rd_value)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: expected wr=%0b data=%h rd=%h, got wr=%0b data=%h rd=%h",
                             e.mem_write, e.mem_write_data, e.rd_value,
                             r.mem_write, r.mem_write_data, r.rd_value);
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    amou_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_ready;
    amou_pkg::rsp_t rsp;

    amo_response_tracker tracker = new();
    int                  tick_count = 0;
    int                  burst_left = 0;
    int                  requests_sent = 0;
    int                  stall_left = 0;
    int                  stall_mode = 0;

    atomic_memory_op_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count == CYCLE_LIMIT)
        begin
            $display("atomic_memory_op_unit regression: fail");
            $finish;
        end
    end

    // accepted requests and responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                tracker.note_request(req);
            if (rsp_valid && rsp_ready)
                tracker.check_response(rsp);
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 256);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= tick_count[2];
        endcase
    end

    function automatic amou_pkg::req_t make_req(logic [1:0] kind, logic wide, logic [3:0] op,
                                                logic [amou_pkg::XLEN-1:0] addr,
                                                logic [amou_pkg::XLEN-1:0] mem,
                                                logic [amou_pkg::XLEN-1:0] opnd);
        amou_pkg::req_t r;
        r.kind          = kind;
        r.wide          = wide;
        r.amo_op        = op;
        r.address       = addr;
        r.mem_read_data = mem;
        r.operand       = opnd;
        return r;
    endfunction

    function automatic logic [amou_pkg::XLEN-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return {$urandom, 32'h8000_0000};
            5:       return {$urandom, 32'h7FFF_FFFF};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [amou_pkg::XLEN-1:0] rand_address();
        case ($urandom_range(0, 7))
            0:       return 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15));
            1:       return 64'($urandom_range(0, 15));
            2:       return {$urandom, $urandom} & ~64'h7;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] rand_op();
        if ($urandom_range(0, 15) == 0)
            return 4'($urandom_range(int'(amou_pkg::AMO_MAXU) + 1, int'(AMO_LAST_CODE)));
        return 4'($urandom_range(int'(amou_pkg::AMO_SWAP), int'(amou_pkg::AMO_MAXU)));
    endfunction

    function automatic logic rand_wide();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_request(input amou_pkg::req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        burst_left--;
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic random_sequence();
        logic [amou_pkg::XLEN-1:0] lr_addr;
        logic [amou_pkg::XLEN-1:0] sc_addr;
        int                        n_amo;
        int                        pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
        begin
            lr_addr = rand_address();
            send_request(make_req(amou_pkg::KIND_LR, rand_wide(), 4'($urandom),
                                  lr_addr, rand_word(), rand_word()));
            n_amo = $urandom_range(0, 2);
            repeat (n_amo)
                send_request(make_req(amou_pkg::KIND_AMO, rand_wide(), rand_op(),
                                      rand_address(), rand_word(), rand_word()));
            case ($urandom_range(0, 3))
                0, 1:    sc_addr = lr_addr;
                2:       sc_addr = lr_addr + 64'($urandom_range(0, 16)) - 64'd8;
                default: sc_addr = rand_address();
            endcase
            send_request(make_req(amou_pkg::KIND_SC, rand_wide(), 4'($urandom),
                                  sc_addr, rand_word(), rand_word()));
        end
        else if (pick < 15)
        begin
            send_request(make_req(amou_pkg::KIND_AMO, rand_wide(), rand_op(),
                                  rand_address(), rand_word(), rand_word()));
        end
        else if (pick < 17)
        begin
            send_request(make_req(amou_pkg::KIND_SC, rand_wide(), 4'($urandom),
                                  rand_address(), rand_word(), rand_word()));
        end
        else if (pick < 19)
        begin
            send_request(make_req(amou_pkg::KIND_LR, rand_wide(), 4'($urandom),
                                  rand_address(), rand_word(), rand_word()));
        end
        else
        begin
            send_request(make_req(KIND_UNUSED, rand_wide(), 4'($urandom),
                                  rand_address(), rand_word(), rand_word()));
        end
    endtask

    initial
    begin
        logic [amou_pkg::XLEN-1:0] base;
        logic                      drained_mid;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_ready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        base = 64'h0000_0000_1000_0040;
        // sc with no reservation
        send_request(make_req(amou_pkg::KIND_SC, 1'b1, amou_pkg::AMO_SWAP, base, '0, '1));
        // narrow lr sign extension, sc success with zero-extended data, repeat fails
        send_request(make_req(amou_pkg::KIND_LR, 1'b0, amou_pkg::AMO_SWAP, base,
                              64'h1234_5678_8000_0000, '0));
        send_request(make_req(amou_pkg::KIND_SC, 1'b0, amou_pkg::AMO_SWAP, base, '0,
                              64'hDEAD_BEEF_CAFE_F00D));
        send_request(make_req(amou_pkg::KIND_SC, 1'b0, amou_pkg::AMO_SWAP, base, '0, '1));
        // wide sc must clear the reservation too
        send_request(make_req(amou_pkg::KIND_LR, 1'b1, amou_pkg::AMO_SWAP, base, '1, '0));
        send_request(make_req(amou_pkg::KIND_SC, 1'b1, amou_pkg::AMO_SWAP, base, '0, '1));
        send_request(make_req(amou_pkg::KIND_SC, 1'b1, amou_pkg::AMO_SWAP, base, '0, '1));
        // narrow sc in the upper half of a wide reservation
        send_request(make_req(amou_pkg::KIND_LR, 1'b1, amou_pkg::AMO_SWAP, base,
                              64'h7FFF_FFFF_FFFF_FFFF, '0));
        send_request(make_req(amou_pkg::KIND_SC, 1'b0, amou_pkg::AMO_SWAP, base + 64'd4, '0,
                              64'h0000_0000_FFFF_FFFF));
        // wide sc not covered by a narrow reservation
        send_request(make_req(amou_pkg::KIND_LR, 1'b0, amou_pkg::AMO_SWAP, base,
                              64'h0000_0000_7FFF_FFFF, '0));
        send_request(make_req(amou_pkg::KIND_SC, 1'b1, amou_pkg::AMO_SWAP, base, '0, '1));
        // address wrap at the top of memory
        send_request(make_req(amou_pkg::KIND_LR, 1'b0, amou_pkg::AMO_SWAP, '1,
                              64'hFFFF_FFFF_0000_0001, '0));
        send_request(make_req(amou_pkg::KIND_SC, 1'b0, amou_pkg::AMO_SWAP, '1, '0,
                              64'h8000_0000_8000_0000));
        send_request(make_req(amou_pkg::KIND_LR, 1'b1, amou_pkg::AMO_SWAP,
                              64'hFFFF_FFFF_FFFF_FFF8, 64'h8000_0000_0000_0000, '0));
        // every amo op, alternating width; reservation must survive them
        for (int op = int'(amou_pkg::AMO_SWAP); op <= int'(amou_pkg::AMO_MAXU); op++)
            send_request(make_req(amou_pkg::KIND_AMO, op[0], 4'(op), base + 64'(op * 8),
                                  op[0] ? 64'h8000_0000_0000_0001 : 64'h0000_0000_FFFF_FFFE,
                                  op[0] ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_0000_0003));
        send_request(make_req(amou_pkg::KIND_SC, 1'b1, amou_pkg::AMO_SWAP,
                              64'hFFFF_FFFF_FFFF_FFF8, '0, '1));
        // unknown amo op and unknown kind
        send_request(make_req(amou_pkg::KIND_AMO, 1'b0, AMO_LAST_CODE, base, '1, '1));
        send_request(make_req(KIND_UNUSED, 1'b1, amou_pkg::AMO_ADD, base, '1, '1));

        drained_mid = 1'b0;
        while (requests_sent < RANDOM_ITEMS + 26)
        begin
            random_sequence();
            if ((!drained_mid && requests_sent > RANDOM_ITEMS / 2) ||
                $urandom_range(0, 63) == 0)
            begin
                wait_for_drain();
                drained_mid = 1'b1;
            end
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("atomic_memory_op_unit regression: pass");
        else
            $display("atomic_memory_op_unit regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/amou_pkg.sv
design/amou_alu.sv
design/atomic_memory_op_unit.sv
tb/atomic_memory_op_unit_test.sv
